[hw/rtl/hpp_pkg.sv]
// Shared types and constants of the handshake packet parser.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package hpp_pkg;

    localparam int NUM_VERSIONS      = 6;
    localparam int CFG_INDEX_W       = 3;
    localparam int MAX_ADDRESS_BYTES = 255;
    localparam int MAX_VARINT_BYTES  = 5;
    localparam int QUEUE_DEPTH       = 4;

    // Status codes of a summary word.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_ADDRESS = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_BAD_STATE   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED   = 3'd4;

    // Requested next states that are accepted.
    localparam logic [31:0] REQ_STATUS = 32'd1;
    localparam logic [31:0] REQ_LOGIN  = 32'd2;

    localparam logic KIND_ADDRESS = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [NUM_VERSIONS-1:0][31:0] VERSION_RESET = {
        32'd763, 32'd759, 32'd735, 32'd335, 32'd47, 32'd5
    };

    typedef logic [NUM_VERSIONS-1:0][31:0] t_version_list;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } t_in_word;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  address_byte;
        logic [2:0]  status;
        logic [31:0] version_seen;
        logic [15:0] port_seen;
        logic [31:0] requested_state;
        logic [1:0]  session_state;
        logic [7:0]  address_length;
        logic        last_of_run;
    } t_out_word;

    // One queue entry: what a single input byte asks the back end to send.
    typedef struct packed {
        logic        has_addr;
        logic        has_sum;
        logic [7:0]  addr_byte;
        logic [2:0]  status;
        logic [31:0] version;
        logic [15:0] port;
        logic [31:0] req_state;
        logic [1:0]  session;
        logic [7:0]  addr_len;
    } t_cmd;

endpackage

`default_nettype wire

[hw/rtl/hpp_front.sv]
// Front end of the handshake packet parser: takes bytes, walks the packet
// fields and builds queue entries. Depends on hpp_pkg.
`default_nettype none

module hpp_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire hpp_pkg::t_in_word     i_in_data,
    output logic                       o_in_stall,
    input  wire hpp_pkg::t_version_list i_versions,
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output hpp_pkg::t_cmd              o_q_data
);

    typedef enum logic [2:0] {
        PH_VERSION,
        PH_ADDR_LEN,
        PH_ADDR,
        PH_PORT_HI,
        PH_PORT_LO,
        PH_STATE,
        PH_DONE,
        PH_SKIP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_vcnt, n_vcnt;
    logic [31:0] r_version, n_version;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_port, n_port;
    logic [31:0] r_state_val, n_state_val;
    logic [2:0]  r_err, n_err;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] acc_or;
    logic [2:0]  cnt_inc;
    logic        vdone;
    logic [31:0] vval;
    logic        has_addr;
    logic        ver_ok;
    hpp_pkg::t_cmd cmd;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign b          = i_in_data.data_byte;

    // Varint step: seven payload bits per byte, groups beyond bit 31 drop out.
    assign acc_or  = r_acc | (32'(b[6:0]) << (6'(r_vcnt) * 6'd7));
    assign cnt_inc = r_vcnt + 3'd1;
    assign vdone   = !b[7] || (cnt_inc >= 3'(hpp_pkg::MAX_VARINT_BYTES));
    assign vval    = b[7] ? 32'hFFFF_FFFF : acc_or;

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_vcnt      = r_vcnt;
        n_version   = r_version;
        n_left      = r_left;
        n_count     = r_count;
        n_port      = r_port;
        n_state_val = r_state_val;
        n_err       = r_err;
        has_addr    = 1'b0;
        unique case (r_phase)
            PH_VERSION: begin
                n_acc  = acc_or;
                n_vcnt = cnt_inc;
                if (vdone) begin
                    n_version = vval;
                    n_acc     = '0;
                    n_vcnt    = '0;
                    n_phase   = PH_ADDR_LEN;
                end
            end
            PH_ADDR_LEN: begin
                n_acc  = acc_or;
                n_vcnt = cnt_inc;
                if (vdone) begin
                    n_acc  = '0;
                    n_vcnt = '0;
                    if (vval >= 32'd1 && vval <= 32'(hpp_pkg::MAX_ADDRESS_BYTES)) begin
                        n_left  = vval[7:0];
                        n_phase = PH_ADDR;
                    end else begin
                        n_err   = hpp_pkg::ST_BAD_ADDRESS;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_ADDR: begin
                has_addr = 1'b1;
                n_count  = r_count + 8'd1;
                n_left   = r_left - 8'd1;
                if (r_left == 8'd1) begin
                    n_phase = PH_PORT_HI;
                end
            end
            PH_PORT_HI: begin
                n_acc   = {24'd0, b};
                n_phase = PH_PORT_LO;
            end
            PH_PORT_LO: begin
                n_port  = {r_acc[7:0], b};
                n_acc   = '0;
                n_phase = PH_STATE;
            end
            PH_STATE: begin
                n_acc  = acc_or;
                n_vcnt = cnt_inc;
                if (vdone) begin
                    n_state_val = vval;
                    n_acc       = '0;
                    n_vcnt      = '0;
                    n_phase     = PH_DONE;
                end
            end
            PH_DONE: begin
            end
            PH_SKIP: begin
            end
        endcase
    end

    // The version is settled long before the packet can be complete.
    always_comb begin
        ver_ok = 1'b0;
        for (int i = 0; i < hpp_pkg::NUM_VERSIONS; i++) begin
            if (r_version == i_versions[i]) begin
                ver_ok = 1'b1;
            end
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.has_addr  = has_addr;
        cmd.has_sum   = i_in_data.end_of_packet;
        cmd.addr_byte = b;
        if (n_phase == PH_SKIP) begin
            cmd.status = n_err;
        end else begin
            cmd.version   = n_version;
            cmd.port      = n_port;
            cmd.req_state = n_state_val;
            cmd.addr_len  = n_count;
            if (n_phase != PH_DONE) begin
                cmd.status = hpp_pkg::ST_TRUNCATED;
            end else if (!ver_ok) begin
                cmd.status = hpp_pkg::ST_BAD_VERSION;
            end else if (n_state_val == hpp_pkg::REQ_STATUS ||
                         n_state_val == hpp_pkg::REQ_LOGIN) begin
                cmd.status  = hpp_pkg::ST_OK;
                cmd.session = n_state_val[1:0];
            end else begin
                cmd.status = hpp_pkg::ST_BAD_STATE;
            end
        end
    end

    assign o_q_push = accept && (has_addr || i_in_data.end_of_packet);
    assign o_q_data = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in_data.end_of_packet)) begin
            r_phase     <= PH_VERSION;
            r_acc       <= '0;
            r_vcnt      <= '0;
            r_version   <= '0;
            r_left      <= '0;
            r_count     <= '0;
            r_port      <= '0;
            r_state_val <= '0;
            r_err       <= hpp_pkg::ST_OK;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_vcnt      <= n_vcnt;
            r_version   <= n_version;
            r_left      <= n_left;
            r_count     <= n_count;
            r_port      <= n_port;
            r_state_val <= n_state_val;
            r_err       <= n_err;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hpp_fifo.sv]
// Short queue of parser entries between front and back end.
// Depends on hpp_pkg for the entry type.
`default_nettype none

module hpp_fifo #(
    parameter int DEPTH = hpp_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hpp_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output hpp_pkg::t_cmd      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hpp_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hpp_back.sv]
// Back end of the handshake packet parser: turns queue entries into result
// words in an output register. Depends on hpp_pkg.
`default_nettype none

module hpp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire hpp_pkg::t_cmd i_q_data,
    output logic               o_q_pop,
    output logic               o_out_valid,
    output hpp_pkg::t_out_word o_out_data,
    input  wire logic          i_out_stall
);

    logic               r_valid, n_valid;
    logic               r_addr_done, n_addr_done;
    hpp_pkg::t_out_word r_word, n_word;
    logic               can_load;

    assign can_load = !r_valid || !i_out_stall;

    always_comb begin
        n_valid     = r_valid && i_out_stall;
        n_addr_done = r_addr_done;
        n_word      = r_word;
        o_q_pop     = 1'b0;
        if (can_load && !i_q_empty) begin
            n_valid = 1'b1;
            n_word  = '0;
            // An entry with both an address byte and a summary sends the byte first.
            if (i_q_data.has_addr && !r_addr_done) begin
                n_word.item_kind    = hpp_pkg::KIND_ADDRESS;
                n_word.address_byte = i_q_data.addr_byte;
                if (i_q_data.has_sum) begin
                    n_addr_done = 1'b1;
                end else begin
                    o_q_pop = 1'b1;
                end
            end else begin
                n_word.item_kind       = hpp_pkg::KIND_SUMMARY;
                n_word.status          = i_q_data.status;
                n_word.version_seen    = i_q_data.version;
                n_word.port_seen       = i_q_data.port;
                n_word.requested_state = i_q_data.req_state;
                n_word.session_state   = i_q_data.session;
                n_word.address_length  = i_q_data.addr_len;
                n_word.last_of_run     = 1'b1;
                n_addr_done            = 1'b0;
                o_q_pop                = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_addr_done <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_addr_done <= n_addr_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_word;

endmodule

`default_nettype wire

[hw/rtl/handshake_packet_parser.sv]
// Top level of the handshake packet parser and its version registers.
// Depends on hpp_pkg, hpp_front, hpp_fifo and hpp_back.
`default_nettype none

// The parser takes one packet byte per cycle unless the queue is full: the
// front end updates its field registers per accepted byte and writes one
// queue entry for every byte that yields results. The back end sends one
// result word per cycle unless the output stalls, so a final byte that is
// also an address byte yields two words. A result passes through the queue
// and then the output register. The input stalls only while the queue of
// QUEUE_DEPTH entries is full, which happens when the output is held. The
// version registers are always ready and should be written while idle.
module handshake_packet_parser #(
    parameter int QUEUE_DEPTH = hpp_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire hpp_pkg::t_in_word              i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output hpp_pkg::t_out_word                  o_out_data,
    input  wire logic                           i_out_stall,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [hpp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);

    hpp_pkg::t_version_list r_versions;
    logic                   q_push, q_full, q_pop, q_empty;
    hpp_pkg::t_cmd          q_wr_data, q_rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_versions <= hpp_pkg::VERSION_RESET;
        end else if (i_cfg_valid &&
                     i_cfg_index < hpp_pkg::CFG_INDEX_W'(hpp_pkg::NUM_VERSIONS)) begin
            r_versions[i_cfg_index] <= i_cfg_data;
        end
    end

    hpp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_versions (r_versions),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wr_data)
    );

    hpp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    hpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rd_data),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

[hw/rtl/hpp_checker.sv]
// Port-level checks of the handshake packet parser, bound to its top level.
// Depends on hpp_pkg and handshake_packet_parser.
`default_nettype none

module hpp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire hpp_pkg::t_out_word o_out_data,
    input wire logic               i_out_stall
);

    // A held result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word changed while stalled");

    // Only a summary word closes a packet.
    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.item_kind == o_out_data.last_of_run))
        else $error("last_of_run does not match item kind");

    // An address word carries no status, version, session or length.
    a_addr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.item_kind == hpp_pkg::KIND_ADDRESS |->
            o_out_data.status == hpp_pkg::ST_OK && o_out_data.version_seen == '0 &&
            o_out_data.session_state == '0 && o_out_data.address_length == '0)
        else $error("address word carries summary fields");

    // A session change is granted only on a clean packet.
    a_session_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != hpp_pkg::ST_OK |->
            o_out_data.session_state == '0)
        else $error("session state set on a failed packet");

    // A bad address length hides every decoded field.
    a_bad_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.item_kind == hpp_pkg::KIND_SUMMARY &&
        o_out_data.status == hpp_pkg::ST_BAD_ADDRESS |->
            o_out_data.address_length == '0 && o_out_data.version_seen == '0 &&
            o_out_data.port_seen == '0 && o_out_data.requested_state == '0)
        else $error("bad address summary carries decoded fields");

endmodule

bind handshake_packet_parser hpp_checker u_hpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
